[rtl/teq_pkg.sv]
// Package for the touch event qualifier: report kinds, actions, event codes
// and the report struct passed from the qualifier state machine to the top level.
// No dependencies.
package teq_pkg;

  localparam logic [2:0] EV_NOTHING = 3'd0;
  localparam logic [2:0] EV_CLICK   = 3'd1;
  localparam logic [2:0] EV_HOLD    = 3'd2;
  localparam logic [2:0] EV_RELEASE = 3'd3;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_HOLD    = 2'd2,
    KIND_RELEASE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ACT_PRESS   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_HOLDING = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    PT_ZERO  = 3'd0,
    PT_CUR   = 3'd1,
    PT_LEAVE = 3'd2,
    PT_KEEP  = 3'd3,
    PT_SAVED = 3'd4
  } pt_sel_t;

  typedef struct packed {
    kind_t   kind;
    pt_sel_t pt_sel;
  } report_t;

endpackage

[rtl/touch_event_qualifier.sv]
// Top level of the touch event qualifier: input handshake, pending point and
// button state, and the registered result stage. Depends on teq_pkg and teq_fsm.
//
//   channel   direction  tdata                                  tuser
//   s_axis    in         cur_x, cur_y, leave_x, leave_y          raw_event
//   m_axis    out        press_x, press_y, release_x, release_y  action
//
// One sample per cycle while m_axis does not stall; a result, if any, appears in the cycle after its sample.
// The qualifier state and the point registers update in the accept cycle.
// The result register holds one transfer; input is taken while it is empty
// or being emptied, so a stall on m_axis stops s_axis in the same cycle.
// Reset clears the state machine, the button flag and all latched points.
module touch_event_qualifier #(
  parameter int COORD_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        s_tvalid,
  output logic                                        s_tready,
  // cur_x, cur_y, leave_x, leave_y
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]          s_tdata,
  // raw_event
  input  logic [2:0]                                  s_tuser,
  output logic                                        m_tvalid,
  input  logic                                        m_tready,
  // press_x, press_y, release_x, release_y
  output logic [((4*COORD_BITS+7)/8)*8-1:0]          m_tdata,
  // action
  output logic [1:0]                                  m_tuser
);

  localparam int CB     = COORD_BITS;
  localparam int DATA_W = ((4*COORD_BITS+7)/8)*8;

  logic             in_acc;
  teq_pkg::report_t rep;

  logic [CB-1:0] cur_x, cur_y, leave_x, leave_y;
  logic [CB-1:0] pending_x, pending_y, pending_x_next, pending_y_next;
  logic [CB-1:0] saved_press_x, saved_press_y;
  logic [CB-1:0] saved_press_x_next, saved_press_y_next;
  logic [CB-1:0] press_point_x, press_point_y, press_point_x_next, press_point_y_next;
  logic [CB-1:0] release_point_x, release_point_y;
  logic [CB-1:0] release_point_x_next, release_point_y_next;
  logic          button_down, button_down_next;
  logic          emit;
  teq_pkg::action_t act;

  assign s_tready = !m_tvalid || m_tready;
  assign in_acc   = s_tvalid && s_tready;

  assign cur_x   = s_tdata[CB-1:0];
  assign cur_y   = s_tdata[2*CB-1:CB];
  assign leave_x = s_tdata[3*CB-1:2*CB];
  assign leave_y = s_tdata[4*CB-1:3*CB];

  teq_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_acc),
    .raw_event (s_tuser),
    .rep       (rep)
  );

  always_comb begin
    pending_x_next     = pending_x;
    pending_y_next     = pending_y;
    saved_press_x_next = saved_press_x;
    saved_press_y_next = saved_press_y;
    case (rep.pt_sel)
      teq_pkg::PT_CUR: begin
        pending_x_next = cur_x;
        pending_y_next = cur_y;
      end
      teq_pkg::PT_LEAVE: begin
        pending_x_next = leave_x;
        pending_y_next = leave_y;
      end
      teq_pkg::PT_KEEP: ;
      teq_pkg::PT_SAVED: begin
        pending_x_next     = saved_press_x;
        pending_y_next     = saved_press_y;
        saved_press_x_next = '0;
        saved_press_y_next = '0;
      end
      default: begin
        pending_x_next = '0;
        pending_y_next = '0;
      end
    endcase
    if (rep.kind == teq_pkg::KIND_PRESS) begin
      saved_press_x_next = cur_x;
      saved_press_y_next = cur_y;
    end
  end

  always_comb begin
    press_point_x_next   = press_point_x;
    press_point_y_next   = press_point_y;
    release_point_x_next = release_point_x;
    release_point_y_next = release_point_y;
    button_down_next     = button_down;
    emit                 = 1'b0;
    act                  = teq_pkg::ACT_HOLDING;
    case (rep.kind)
      teq_pkg::KIND_PRESS: begin
        if (!button_down) begin
          press_point_x_next = pending_x_next;
          press_point_y_next = pending_y_next;
          button_down_next   = 1'b1;
          emit               = 1'b1;
          act                = teq_pkg::ACT_PRESS;
        end
      end
      teq_pkg::KIND_RELEASE: begin
        if (button_down) begin
          release_point_x_next = pending_x_next;
          release_point_y_next = pending_y_next;
          button_down_next     = 1'b0;
          emit                 = 1'b1;
          act                  = teq_pkg::ACT_RELEASE;
        end
      end
      teq_pkg::KIND_HOLD: begin
        release_point_x_next = pending_x_next;
        release_point_y_next = pending_y_next;
        emit                 = 1'b1;
        act                  = teq_pkg::ACT_HOLDING;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_x       <= '0;
      pending_y       <= '0;
      saved_press_x   <= '0;
      saved_press_y   <= '0;
      press_point_x   <= '0;
      press_point_y   <= '0;
      release_point_x <= '0;
      release_point_y <= '0;
      button_down     <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (in_acc) begin
        pending_x       <= pending_x_next;
        pending_y       <= pending_y_next;
        saved_press_x   <= saved_press_x_next;
        saved_press_y   <= saved_press_y_next;
        press_point_x   <= press_point_x_next;
        press_point_y   <= press_point_y_next;
        release_point_x <= release_point_x_next;
        release_point_y <= release_point_y_next;
        button_down     <= button_down_next;
        m_tvalid        <= emit;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      m_tuser <= act;
      m_tdata <= DATA_W'({release_point_y_next, release_point_x_next,
                          press_point_y_next, press_point_x_next});
    end
  end

  a_press_sets_down: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == teq_pkg::ACT_PRESS) |-> button_down)
    else $error("press result while button is up");

  a_release_clears_down: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == teq_pkg::ACT_RELEASE) |-> !button_down)
    else $error("release result while button is down");

  a_release_clears_saved: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == teq_pkg::ACT_RELEASE) |->
      (saved_press_x == '0) && (saved_press_y == '0))
    else $error("saved press point not cleared after release");

  a_press_while_down_silent: assert property (@(posedge clk) disable iff (rst)
    in_acc && (rep.kind == teq_pkg::KIND_PRESS) && button_down |=> !m_tvalid)
    else $error("press emitted while button already down");

endmodule

[rtl/teq_fsm.sv]
// Eight-state touch qualifier: confirms presses and releases over three samples
// and forms the pending report for each accepted sample.
// Depends on teq_pkg.
module teq_fsm (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [2:0]       raw_event,
  output teq_pkg::report_t rep
);

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_TRYCLICK1 = 3'd1,
    ST_TRYCLICK2 = 3'd2,
    ST_CLICK     = 3'd3,
    ST_HOLD      = 3'd4,
    ST_TRYREL1   = 3'd5,
    ST_TRYREL2   = 3'd6,
    ST_RELEASE   = 3'd7
  } state_t;

  state_t state;
  state_t state_next;
  logic   take_leave;

  always_comb begin
    state_next = state;
    take_leave = 1'b0;
    case (raw_event)
      teq_pkg::EV_NOTHING: begin
        if (state == ST_IDLE || state == ST_RELEASE) state_next = ST_IDLE;
        else if (state == ST_TRYREL1) state_next = ST_TRYREL2;
        else if (state == ST_TRYREL2) state_next = ST_RELEASE;
      end
      teq_pkg::EV_CLICK: begin
        if (state == ST_IDLE) state_next = ST_TRYCLICK1;
        else if (state == ST_TRYREL1 || state == ST_TRYREL2) state_next = ST_HOLD;
      end
      teq_pkg::EV_HOLD: begin
        if (state == ST_HOLD || state == ST_CLICK) state_next = ST_HOLD;
        else if (state == ST_TRYCLICK1) state_next = ST_TRYCLICK2;
        else if (state == ST_TRYCLICK2) state_next = ST_CLICK;
      end
      teq_pkg::EV_RELEASE: begin
        if (state == ST_HOLD || state == ST_CLICK) begin
          state_next = ST_TRYREL1;
          take_leave = 1'b1;
        end else if (state == ST_TRYCLICK1 || state == ST_TRYCLICK2) begin
          state_next = ST_TRYREL1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_next)
      ST_CLICK: begin
        rep.kind   = teq_pkg::KIND_PRESS;
        rep.pt_sel = teq_pkg::PT_CUR;
      end
      ST_HOLD: begin
        rep.kind   = teq_pkg::KIND_HOLD;
        rep.pt_sel = teq_pkg::PT_CUR;
      end
      ST_TRYREL1, ST_TRYREL2: begin
        rep.kind   = teq_pkg::KIND_HOLD;
        rep.pt_sel = take_leave ? teq_pkg::PT_LEAVE : teq_pkg::PT_KEEP;
      end
      ST_RELEASE: begin
        rep.kind   = teq_pkg::KIND_RELEASE;
        rep.pt_sel = teq_pkg::PT_SAVED;
      end
      default: begin
        rep.kind   = teq_pkg::KIND_NONE;
        rep.pt_sel = teq_pkg::PT_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule
